### rtl/rfvd_pkg.sv
// Shared types, codes and lookup functions for the radar frame validate/decode unit.
// No dependencies; every other rtl file refers to this package by scoped names.
package rfvd_pkg;

  localparam int unsigned MaxTargets = 4;
  localparam int unsigned HdrLen     = 8;
  localparam int unsigned IdxW       = 17;
  localparam int unsigned TotalW     = IdxW + 1;

  localparam logic [7:0]  SofByte = 8'h01;
  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};

  localparam logic [15:0] TypeA13  = 16'h0A13;
  localparam logic [15:0] TypeA14  = 16'h0A14;
  localparam logic [15:0] TypeA15  = 16'h0A15;
  localparam logic [15:0] TypeA16  = 16'h0A16;
  localparam logic [15:0] TypeTgtA = 16'h0A08;
  localparam logic [15:0] TypeTgtB = 16'h0A04;
  localparam logic [15:0] TypeF09  = 16'h0F09;
  localparam logic [15:0] TypeFfff = 16'hFFFF;

  typedef enum logic [3:0] {
    StOk       = 4'd0,
    StShort    = 4'd1,
    StBadStart = 4'd2,
    StLength   = 4'd3,
    StHdrSum   = 4'd4,
    StPaySum   = 4'd5,
    StType     = 4'd6,
    StPayShort = 4'd7,
    StCount    = 4'd8
  } status_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] frame_type;
    logic [15:0] payload_length;
    logic        presence;
    logic [2:0]  clamped_targets;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
  } out_item_t;

  // Per-frame summary handed from the byte front end to the check back end.
  typedef struct packed {
    logic [TotalW-1:0] total;
    logic              start_ok;
    logic              hdr_ok;
    logic              pay_ok;
    logic [15:0]       length;
    logic [15:0]       ftype;
    logic [31:0]       word0;
    logic [31:0]       word1;
  } frame_sum_t;

  typedef struct packed {
    logic       known;
    logic [3:0] need;
  } min_len_t;

  function automatic min_len_t min_payload(input logic [15:0] t);
    min_len_t r;
    r.known = 1'b1;
    case (t)
      TypeA13:  r.need = 4'd12;
      TypeA14:  r.need = 4'd4;
      TypeA15:  r.need = 4'd4;
      TypeA16:  r.need = 4'd8;
      TypeF09:  r.need = 4'd1;
      TypeFfff: r.need = 4'd4;
      TypeTgtA: r.need = 4'd4;
      TypeTgtB: r.need = 4'd4;
      default: begin
        r.known = 1'b0;
        r.need  = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage

### rtl/rfvd_front.sv
// Byte front end: tracks position, XOR sums and header/payload fields of a frame.
// Depends on rfvd_pkg; pushes one frame summary into the queue at the last byte.
module rfvd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  rfvd_pkg::in_item_t   in_data_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output rfvd_pkg::frame_sum_t sum_o
);

  logic [rfvd_pkg::IdxW-1:0] idx_q, idx_d;
  logic [7:0]  hx_q, hx_d, px_q, px_d;
  logic        start_q, start_d, hdr_q, hdr_d, pay_q, pay_d;
  logic [15:0] len_q, len_d, typ_q, typ_d;
  logic [31:0] w0_q, w0_d, w1_q, w1_d;
  logic [7:0]  b;
  logic        last, accept;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign b          = in_data_i.frame_byte;
  assign last       = in_data_i.last_byte;
  assign push_o     = accept & last;

  always_comb begin
    hx_d    = hx_q;
    px_d    = px_q;
    start_d = start_q;
    hdr_d   = hdr_q;
    pay_d   = pay_q;
    len_d   = len_q;
    typ_d   = typ_q;
    w0_d    = w0_q;
    w1_d    = w1_q;
    idx_d   = (idx_q == rfvd_pkg::IdxMax) ? idx_q : idx_q + 1'b1;
    if (idx_q < rfvd_pkg::IdxW'(rfvd_pkg::HdrLen - 1)) begin
      hx_d = hx_q ^ b;
    end
    case (idx_q)
      17'd0: start_d = (b == rfvd_pkg::SofByte);
      17'd3: len_d[15:8] = b;
      17'd4: len_d[7:0] = b;
      17'd5: typ_d[15:8] = b;
      17'd6: typ_d[7:0] = b;
      17'd7: hdr_d = (~hx_q == b);
      17'd1, 17'd2: ;
      default: begin
        if (last) begin
          pay_d = (~px_q == b);
        end else begin
          px_d = px_q ^ b;
          // payload bytes 0..7 sit at positions 8..15
          if (idx_q < 17'd12) begin
            w0_d[{idx_q[1:0], 3'b000} +: 8] = b;
          end else if (idx_q < 17'd16) begin
            w1_d[{idx_q[1:0], 3'b000} +: 8] = b;
          end
        end
      end
    endcase
  end

  always_comb begin
    sum_o.total    = {1'b0, idx_q} + 1'b1;
    sum_o.start_ok = start_d;
    sum_o.hdr_ok   = hdr_d;
    sum_o.pay_ok   = pay_d;
    sum_o.length   = len_d;
    sum_o.ftype    = typ_d;
    sum_o.word0    = w0_d;
    sum_o.word1    = w1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      hx_q    <= '0;
      px_q    <= '0;
      start_q <= 1'b0;
      hdr_q   <= 1'b0;
      pay_q   <= 1'b0;
      len_q   <= '0;
      typ_q   <= '0;
      w0_q    <= '0;
      w1_q    <= '0;
    end else if (accept) begin
      if (last) begin
        // clear per-frame state for the next frame
        idx_q   <= '0;
        hx_q    <= '0;
        px_q    <= '0;
        start_q <= 1'b0;
        hdr_q   <= 1'b0;
        pay_q   <= 1'b0;
        len_q   <= '0;
        typ_q   <= '0;
        w0_q    <= '0;
        w1_q    <= '0;
      end else begin
        idx_q   <= idx_d;
        hx_q    <= hx_d;
        px_q    <= px_d;
        start_q <= start_d;
        hdr_q   <= hdr_d;
        pay_q   <= pay_d;
        len_q   <= len_d;
        typ_q   <= typ_d;
        w0_q    <= w0_d;
        w1_q    <= w1_d;
      end
    end
  end

endmodule

### rtl/rfvd_queue.sv
// Two-entry queue of frame summaries between the front end and the check back end.
// Depends on rfvd_pkg for the frame_sum_t entry type.
module rfvd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  rfvd_pkg::frame_sum_t push_data_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output rfvd_pkg::frame_sum_t pop_data_o
);

  rfvd_pkg::frame_sum_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign valid_o    = (cnt_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/rfvd_back.sv
// Check back end: ranks the frame checks, clamps the target count, keeps the
// good/bad counters and holds the result in an output register. Uses rfvd_pkg.
module rfvd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  rfvd_pkg::frame_sum_t q_data_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rfvd_pkg::out_item_t  out_data_o
);

  rfvd_pkg::min_len_t  ml;
  rfvd_pkg::status_e   st;
  rfvd_pkg::out_item_t res_d, res_q;
  logic        out_valid_q;
  logic [31:0] good_q, bad_q;
  logic [2:0]  tcnt;
  logic        is_tgt;
  logic [15:0] tgt_room;

  assign pop_o = q_valid_i & (~out_valid_q | out_ready_i);

  always_comb begin
    ml       = rfvd_pkg::min_payload(q_data_i.ftype);
    is_tgt   = (q_data_i.ftype == rfvd_pkg::TypeTgtA) ||
               (q_data_i.ftype == rfvd_pkg::TypeTgtB);
    tgt_room = {4'd0, q_data_i.word0[7:0], 4'd0} + 16'd4;
    tcnt     = 3'd0;
    if (q_data_i.total < rfvd_pkg::TotalW'(rfvd_pkg::HdrLen + 1)) begin
      st = rfvd_pkg::StShort;
    end else if (!q_data_i.start_ok) begin
      st = rfvd_pkg::StBadStart;
    end else if (q_data_i.total !=
                 rfvd_pkg::TotalW'(q_data_i.length) +
                 rfvd_pkg::TotalW'(rfvd_pkg::HdrLen + 1)) begin
      st = rfvd_pkg::StLength;
    end else if (!q_data_i.hdr_ok) begin
      st = rfvd_pkg::StHdrSum;
    end else if (!q_data_i.pay_ok) begin
      st = rfvd_pkg::StPaySum;
    end else if (!ml.known) begin
      st = rfvd_pkg::StType;
    end else if (q_data_i.length < {12'd0, ml.need}) begin
      st = rfvd_pkg::StPayShort;
    end else if (is_tgt) begin
      if ((q_data_i.word0[31:8] != 24'd0) || (q_data_i.length < tgt_room)) begin
        st = rfvd_pkg::StCount;
      end else begin
        st = rfvd_pkg::StOk;
        if (q_data_i.word0[7:0] < 8'(rfvd_pkg::MaxTargets)) begin
          tcnt = q_data_i.word0[2:0];
        end else begin
          tcnt = 3'(rfvd_pkg::MaxTargets);
        end
      end
    end else begin
      st = rfvd_pkg::StOk;
    end

    res_d.status          = st;
    res_d.frame_type      = q_data_i.ftype;
    res_d.payload_length  = q_data_i.length;
    res_d.presence        = (q_data_i.word0[7:0] != 8'd0);
    res_d.clamped_targets = tcnt;
    res_d.first_word      = q_data_i.word0;
    res_d.second_word     = q_data_i.word1;
    res_d.good_frames     = (st == rfvd_pkg::StOk) ? good_q + 32'd1 : good_q;
    res_d.bad_frames      = (st == rfvd_pkg::StOk) ? bad_q : bad_q + 32'd1;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      good_q      <= '0;
      bad_q       <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        good_q      <= res_d.good_frames;
        bad_q       <= res_d.bad_frames;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

### rtl/radar_frame_validate_decode_unit.sv
// Top level of the radar frame validate/decode unit: front end, summary queue
// and check back end. Depends on rfvd_pkg, rfvd_front, rfvd_queue, rfvd_back.
//
//   channel | direction | handshake                   | payload
//   --------+-----------+-----------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o     | in_data_i  (frame byte, last)
//   out     | output    | out_valid_o / out_ready_i   | out_data_o (one result/frame)
//
// One byte is accepted per cycle while in_ready_o is high.
// A byte with last_byte set has its frame summary written to the queue; the check
// stage then loads the result into the output register that drives out_data_o.
// in_ready_o drops only while the two-entry summary queue is full, which
// happens when the output side has stalled across several consecutive frames.
// Reset (rst_ni low, asynchronous) clears per-frame state, the queue, the
// output valid and the good/bad frame counters.
module radar_frame_validate_decode_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rfvd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rfvd_pkg::out_item_t out_data_o
);

  // front end -> queue
  logic                 push;
  rfvd_pkg::frame_sum_t push_sum;
  logic                 q_full;
  // queue -> back end
  logic                 q_valid;
  logic                 pop;
  rfvd_pkg::frame_sum_t pop_sum;

  // Accumulate sums and fields per byte; push a summary at the frame's last byte.
  rfvd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .sum_o      (push_sum)
  );

  // Decouple the byte stream from result delivery.
  rfvd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_sum),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_sum)
  );

  // Rank the checks, update counters and hold the result until taken.
  rfvd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (pop_sum),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### sim/tb_radar_frame_validate_decode_unit.sv
// Self-checking testbench for radar_frame_validate_decode_unit: directed frame table,
// then random well-formed and broken frames, each result checked against a predictor.
// Depends on rfvd_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_radar_frame_validate_decode_unit;

  // Ways a stimulus frame can be built or broken.
  typedef enum logic [2:0] {
    FkGood,
    FkShort,
    FkBadStart,
    FkBadLen,
    FkHdrSum,
    FkPaySum,
    FkNoise
  } frame_kind_e;

  // One directed frame: how to build it and, where obvious, the status it must give.
  typedef struct packed {
    frame_kind_e       kind;
    logic [15:0]       ftype;
    int                plen;
    logic [31:0]       word0;
    int                cut;
    logic              pinned;
    rfvd_pkg::status_e pin;
  } frame_row_t;

  localparam logic [15:0] TypeUnknown   = 16'h1234;
  localparam int          NumDir        = 21;
  localparam int          WatchdogLimit = 3000;
  localparam int          RandBytes     = 80;
  localparam int          RandFrames    = 3;

  // Directed frames: every status code, every type, size boundaries and the clamp.
  localparam frame_row_t DirRows [NumDir] = '{
    '{FkShort,    rfvd_pkg::TypeA14,  4,  32'h0,         1, 1'b1, rfvd_pkg::StShort},
    '{FkShort,    rfvd_pkg::TypeA14,  4,  32'h0,         8, 1'b1, rfvd_pkg::StShort},
    '{FkBadStart, rfvd_pkg::TypeA14,  4,  32'h0,         0, 1'b1, rfvd_pkg::StBadStart},
    '{FkBadLen,   rfvd_pkg::TypeA14,  4,  32'h0,         0, 1'b1, rfvd_pkg::StLength},
    '{FkHdrSum,   rfvd_pkg::TypeA14,  4,  32'h0,         0, 1'b1, rfvd_pkg::StHdrSum},
    '{FkPaySum,   rfvd_pkg::TypeA14,  4,  32'h0,         0, 1'b1, rfvd_pkg::StPaySum},
    '{FkGood,     TypeUnknown,        4,  32'h0,         0, 1'b1, rfvd_pkg::StType},
    '{FkGood,     rfvd_pkg::TypeA14,  0,  32'h0,         0, 1'b1, rfvd_pkg::StPayShort},
    '{FkGood,     rfvd_pkg::TypeA13,  11, 32'h0,         0, 1'b1, rfvd_pkg::StPayShort},
    '{FkGood,     rfvd_pkg::TypeA13,  12, 32'hFFFF_FFFF, 0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeA15,  4,  32'h0,         0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeA16,  8,  32'h8000_0001, 0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeF09,  1,  32'h0,         0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeF09,  1,  32'hFF,        0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeFfff, 4,  32'h1,         0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeTgtA, 4,  32'h0,         0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeTgtB, 20, 32'd1,         0, 1'b1, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeTgtA, 84, 32'd5,         0, 1'b0, rfvd_pkg::StOk},
    '{FkGood,     rfvd_pkg::TypeTgtA, 19, 32'd1,         0, 1'b1, rfvd_pkg::StCount},
    '{FkGood,     rfvd_pkg::TypeTgtB, 8,  32'd256,       0, 1'b1, rfvd_pkg::StCount},
    '{FkGood,     rfvd_pkg::TypeTgtA, 3,  32'h0,         0, 1'b1, rfvd_pkg::StPayShort}
  };

  localparam logic [15:0] KnownTypes [8] = '{
    rfvd_pkg::TypeA13, rfvd_pkg::TypeA14, rfvd_pkg::TypeA15, rfvd_pkg::TypeA16,
    rfvd_pkg::TypeF09, rfvd_pkg::TypeFfff, rfvd_pkg::TypeTgtA, rfvd_pkg::TypeTgtB
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  rfvd_pkg::in_item_t  in_data     = '0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  rfvd_pkg::out_item_t out_data;

  // Predictor state: per-frame capture plus the two running frame counters.
  logic [rfvd_pkg::IdxW-1:0] byte_pos;
  logic [7:0]      hdr_acc;
  logic [7:0]      pay_acc;
  logic            sof_ok;
  logic            hsum_match;
  logic            psum_match;
  logic [15:0]     len_hdr;
  logic [15:0]     type_hdr;
  logic [31:0]     pay_w0;
  logic [31:0]     pay_w1;
  logic [31:0]     ok_total;
  logic [31:0]     rej_total;

  rfvd_pkg::out_item_t decoded_q [$];   // expected results, oldest first
  int          status_pin_q [$]; // table status per frame, -1 where not pinned
  logic [7:0]  frame_bytes [$];  // bytes of the frame being sent

  int errors       = 0;
  int bytes_sent   = 0;
  int frames_sent  = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int stall_left   = 0;
  bit out_quiet    = 1'b0;

  radar_frame_validate_decode_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #4 clk_i = ~clk_i;

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Minimum payload per type code; -1 marks an unknown type.
  function automatic int min_need(input logic [15:0] t);
    case (t)
      rfvd_pkg::TypeA13:                     return 12;
      rfvd_pkg::TypeA16:                     return 8;
      rfvd_pkg::TypeF09:                     return 1;
      rfvd_pkg::TypeA14, rfvd_pkg::TypeA15,
      rfvd_pkg::TypeFfff:                    return 4;
      rfvd_pkg::TypeTgtA, rfvd_pkg::TypeTgtB: return 4;
      default:                               return -1;
    endcase
  endfunction

  task automatic clear_capture();
    byte_pos   = '0;
    hdr_acc    = '0;
    pay_acc    = '0;
    sof_ok     = 1'b0;
    hsum_match = 1'b0;
    psum_match = 1'b0;
    len_hdr    = '0;
    type_hdr   = '0;
    pay_w0     = '0;
    pay_w1     = '0;
  endtask

  // Fold one accepted request into the capture; at the last byte, decode the frame
  // and queue the result it must produce.
  task automatic decode_byte(input rfvd_pkg::in_item_t it);
    logic [7:0]                  b;
    logic [rfvd_pkg::IdxW-1:0]   pos;
    logic [rfvd_pkg::TotalW-1:0] total;
    logic [31:0]                 p;
    logic                        is_tgt;
    int                          need;
    rfvd_pkg::status_e           st;
    logic [2:0]                  tcount;
    rfvd_pkg::out_item_t         r;
    b   = it.frame_byte;
    pos = byte_pos;
    if (pos < rfvd_pkg::IdxW'(rfvd_pkg::HdrLen - 1)) hdr_acc ^= b;
    if (pos == 0) begin
      sof_ok = (b == rfvd_pkg::SofByte);
    end else if (pos == 3) begin
      len_hdr[15:8] = b;
    end else if (pos == 4) begin
      len_hdr[7:0] = b;
    end else if (pos == 5) begin
      type_hdr[15:8] = b;
    end else if (pos == 6) begin
      type_hdr[7:0] = b;
    end else if (pos == 7) begin
      hsum_match = (~hdr_acc == b);
    end else if (pos >= rfvd_pkg::IdxW'(rfvd_pkg::HdrLen)) begin
      if (it.last_byte) begin
        psum_match = (~pay_acc == b);
      end else begin
        // Only the first eight payload bytes land in the words.
        p = 32'(pos) - rfvd_pkg::HdrLen;
        pay_acc ^= b;
        if (p < 4) pay_w0[8*p +: 8] = b;
        else if (p < 8) pay_w1[8*(p-4) +: 8] = b;
      end
    end
    if (byte_pos != rfvd_pkg::IdxMax) byte_pos++;
    if (!it.last_byte) return;

    total  = {1'b0, pos} + rfvd_pkg::TotalW'(1);
    need   = min_need(type_hdr);
    is_tgt = (type_hdr == rfvd_pkg::TypeTgtA) || (type_hdr == rfvd_pkg::TypeTgtB);
    tcount = '0;
    // First failing check wins.
    if (total < rfvd_pkg::TotalW'(rfvd_pkg::HdrLen + 1)) st = rfvd_pkg::StShort;
    else if (!sof_ok)                                     st = rfvd_pkg::StBadStart;
    else if (total != rfvd_pkg::TotalW'(len_hdr) +
                      rfvd_pkg::TotalW'(rfvd_pkg::HdrLen + 1)) st = rfvd_pkg::StLength;
    else if (!hsum_match)                                 st = rfvd_pkg::StHdrSum;
    else if (!psum_match)                                 st = rfvd_pkg::StPaySum;
    else if (need < 0)                                    st = rfvd_pkg::StType;
    else if (int'(len_hdr) < need)                        st = rfvd_pkg::StPayShort;
    else if (is_tgt && ((pay_w0 > 32'd255) ||
             ({16'd0, len_hdr} < 32'd4 + (pay_w0 << 4)))) st = rfvd_pkg::StCount;
    else begin
      st = rfvd_pkg::StOk;
      if (is_tgt) tcount = (pay_w0 < rfvd_pkg::MaxTargets) ? pay_w0[2:0] :
                                                             3'(rfvd_pkg::MaxTargets);
    end
    if (st == rfvd_pkg::StOk) ok_total++;
    else rej_total++;

    r.status          = st;
    r.frame_type      = type_hdr;
    r.payload_length  = len_hdr;
    r.presence        = (pay_w0[7:0] != 8'd0);
    r.clamped_targets = tcount;
    r.first_word      = pay_w0;
    r.second_word     = pay_w1;
    r.good_frames     = ok_total;
    r.bad_frames      = rej_total;
    decoded_q.push_back(r);
    clear_capture();
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Compare one accepted result against the oldest decoded frame.
  task automatic check_result(input rfvd_pkg::out_item_t got);
    rfvd_pkg::out_item_t want;
    int                  pin;
    results_seen++;
    if (decoded_q.size() == 0) begin
      note_mismatch("result with no frame pending", 32'(got.status), 32'hFFFF_FFFF);
      return;
    end
    want = decoded_q.pop_front();
    pin  = (status_pin_q.size() != 0) ? status_pin_q.pop_front() : -1;
    if (pin >= 0 && got.status !== 4'(pin))
      note_mismatch("status against table", 32'(got.status), 32'(pin));
    if (got.status !== want.status)
      note_mismatch("status", 32'(got.status), 32'(want.status));
    if (got.frame_type !== want.frame_type)
      note_mismatch("frame_type", 32'(got.frame_type), 32'(want.frame_type));
    if (got.payload_length !== want.payload_length)
      note_mismatch("payload_length", 32'(got.payload_length), 32'(want.payload_length));
    if (got.presence !== want.presence)
      note_mismatch("presence", 32'(got.presence), 32'(want.presence));
    if (got.clamped_targets !== want.clamped_targets)
      note_mismatch("clamped_targets", 32'(got.clamped_targets),
                    32'(want.clamped_targets));
    if (got.first_word !== want.first_word)
      note_mismatch("first_word", got.first_word, want.first_word);
    if (got.second_word !== want.second_word)
      note_mismatch("second_word", got.second_word, want.second_word);
    if (got.good_frames !== want.good_frames)
      note_mismatch("good_frames", got.good_frames, want.good_frames);
    if (got.bad_frames !== want.bad_frames)
      note_mismatch("bad_frames", got.bad_frames, want.bad_frames);
  endtask

  // Build the bytes of one frame into frame_bytes. A target frame carries its
  // count in word0; a broken frame differs from a good one in one place only.
  task automatic build_frame(input frame_kind_e kind, input logic [15:0] ftype,
                             input int plen, input logic [31:0] word0, input int cut);
    logic [7:0]  v;
    logic [7:0]  acc;
    logic [15:0] declared;
    int          i;
    int          n;
    frame_bytes.delete();
    if (kind == FkNoise) begin
      n = $urandom_range(1, 40);
      for (i = 0; i < n; i++) frame_bytes.push_back(8'($urandom));
      if ($urandom_range(0, 1) != 0) frame_bytes[0] = rfvd_pkg::SofByte;
      return;
    end
    declared = (kind == FkBadLen) ? 16'(plen + $urandom_range(1, 5)) : 16'(plen);
    if (kind == FkBadStart) begin
      // Anything but the start byte.
      v = 8'($urandom_range(0, 254));
      if (v >= rfvd_pkg::SofByte) v++;
    end else begin
      v = rfvd_pkg::SofByte;
    end
    frame_bytes.push_back(v);
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(declared[15:8]);
    frame_bytes.push_back(declared[7:0]);
    frame_bytes.push_back(ftype[15:8]);
    frame_bytes.push_back(ftype[7:0]);
    acc = '0;
    for (i = 0; i < 7; i++) acc ^= frame_bytes[i];
    v = ~acc;
    if (kind == FkHdrSum) v ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(v);
    acc = '0;
    for (i = 0; i < plen; i++) begin
      v = (i < 4) ? word0[8*i +: 8] : 8'($urandom);
      acc ^= v;
      frame_bytes.push_back(v);
    end
    v = ~acc;
    if (kind == FkPaySum) v ^= 8'($urandom_range(1, 255));
    frame_bytes.push_back(v);
    if (kind == FkShort) begin
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
    end
  endtask

  // Offer one request and hold it until accepted. A gap lowers valid first.
  task automatic send_byte(input rfvd_pkg::in_item_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic send_frame(input logic pinned, input rfvd_pkg::status_e pin,
                            input logic quiet);
    rfvd_pkg::in_item_t it;
    int                 i;
    status_pin_q.push_back(pinned ? int'(pin) : -1);
    for (i = 0; i < frame_bytes.size(); i++) begin
      it.frame_byte = frame_bytes[i];
      it.last_byte  = (i == frame_bytes.size() - 1);
      send_byte(it, quiet ? 0 : pick_gap());
      bytes_sent++;
    end
    frames_sent++;
  endtask

  // Hold the sender until every decoded frame has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  // One random frame: mostly well formed with random content, the rest broken or noise.
  task automatic random_frame();
    frame_kind_e kind;
    logic [15:0] ftype;
    logic [31:0] word0;
    int          plen;
    int          need;
    int          r;
    r = $urandom_range(0, 9);
    ftype = (r < 8) ? KnownTypes[r] : 16'($urandom);
    need  = min_need(ftype);
    if (ftype == rfvd_pkg::TypeTgtA || ftype == rfvd_pkg::TypeTgtB) begin
      r = $urandom_range(0, 19);
      if (r < 14) word0 = $urandom_range(0, 6);
      else if (r < 17) word0 = $urandom_range(7, 20);
      else word0 = $urandom();
      if (word0 > 255) begin
        plen = $urandom_range(4, 40);
      end else begin
        plen = 4 + 16 * word0;
        r = $urandom_range(0, 9);
        if (r < 2) plen -= $urandom_range(1, 16);
        else if (r < 4) plen += $urandom_range(1, 5);
        if (plen < 0) plen = 0;
      end
    end else begin
      word0 = $urandom();
      if (need < 0 || $urandom_range(0, 99) < 15) plen = $urandom_range(0, 12);
      else plen = need + $urandom_range(0, 12);
    end
    r = $urandom_range(0, 99);
    if (r < 72) kind = FkGood;
    else if (r < 76) kind = FkShort;
    else if (r < 80) kind = FkBadStart;
    else if (r < 84) kind = FkBadLen;
    else if (r < 88) kind = FkHdrSum;
    else if (r < 92) kind = FkPaySum;
    else kind = FkNoise;
    build_frame(kind, ftype, plen, word0, $urandom_range(1, 8));
    send_frame(1'b0, rfvd_pkg::StOk, $urandom_range(0, 99) < 15);
  endtask

  // Input side: every accepted request goes to the decoder model.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) decode_byte(in_data);
  end

  // Output side: check accepted results.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) check_result(out_data);
  end

  // Receiver stalls: random gaps, with stretches of steady ready now and then.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 199) == 0) out_quiet = ~out_quiet;
      if (!out_quiet && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
          $display("tb_radar_frame_validate_decode_unit failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    frame_row_t row;
    int         i;
    int         rand_start_bytes;
    int         rand_frames;
    clear_capture();
    ok_total  = '0;
    rej_total = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (i = 0; i < NumDir; i++) begin
      row = DirRows[i];
      build_frame(row.kind, row.ftype, row.plen, row.word0, row.cut);
      send_frame(row.pinned, row.pin, 1'b0);
    end
    drain_results();

    // Random frames until the byte budget and a fair number of frames are spent.
    rand_start_bytes = bytes_sent;
    rand_frames      = 0;
    while (bytes_sent - rand_start_bytes < RandBytes || rand_frames < RandFrames) begin
      random_frame();
      rand_frames++;
      if (rand_frames % 17 == 8) drain_results();
    end

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (decoded_q.size() != 0)
      note_mismatch("frames never reported", 32'(decoded_q.size()), 32'd0);

    $display("covered %0d frames (%0d bytes): all status codes, all types, target clamp,",
             frames_sent, bytes_sent);
    $display("payload length boundaries; %0d results checked, %0d good, %0d bad",
             results_seen, ok_total, rej_total);
    if (errors == 0) begin
      $display("tb_radar_frame_validate_decode_unit passed");
    end else begin
      $display("tb_radar_frame_validate_decode_unit failed");
    end
    $finish;
  end

endmodule
